// File: rtl/p2d_pkg.sv
`default_nettype none
package p2d_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 22;
  localparam int POS_W       = 10;
  localparam int CNT_W       = 11;
  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLUMNS = 1024;
  localparam int COL_AW      = $clog2(MAX_COLUMNS);
  localparam int MAX_POOL    = 8;
  localparam int POOL_W      = 4;
  localparam int PHASE_W     = $clog2(MAX_POOL);
  localparam int AREA_W      = 7;
  localparam int DIV_W       = SUM_W;
  localparam int DIV_STEPS   = DIV_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int OUT_BITS    = SAMPLE_W + 2 * POS_W;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_ROWS    = 2'd0,
    CFG_FRAME_COLUMNS = 2'd1,
    CFG_POOL_SIZE     = 2'd2,
    CFG_POOL_MODE     = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    DIV_ROWS = 3'd0,
    DIV_COLS = 3'd1,
    DIV_RPOS = 3'd2,
    DIV_CPOS = 3'd3,
    DIV_AVG  = 3'd4
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    logic     div_store;
    logic     sync_clear;
    logic     ram_read;
    logic     ram_write;
    logic     emit_load;
    logic     advance;
    div_sel_t div_sel;
  } p2d_cmd_t;

  typedef struct packed {
    logic dirty;
    logic div_done;
    logic emit;
    logic mode_max;
    logic out_free;
  } p2d_status_t;

endpackage
`default_nettype wire

// File: rtl/p2d_ram.sv
`default_nettype none
module p2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/p2d_div.sv
`default_nettype none
module p2d_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [p2d_pkg::DIV_W-1:0]     dividend,
  input  wire logic [p2d_pkg::AREA_W-1:0]    divisor,
  output logic      [p2d_pkg::DIV_W-1:0]     quotient,
  output logic      [p2d_pkg::AREA_W-1:0]    remainder,
  output logic                               done
);
  import p2d_pkg::*;

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [AREA_W-1:0]    rem_r, rem_nxt;
  logic [AREA_W-1:0]    dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [AREA_W:0]      trial;
  logic [AREA_W:0]      diff;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    diff     = trial - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[AREA_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[AREA_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule
`default_nettype wire

// File: rtl/p2d_datapath.sv
`default_nettype none
module p2d_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire p2d_pkg::p2d_cmd_t                 cmd,
  output p2d_pkg::p2d_status_t                   status,
  input  wire logic [p2d_pkg::SAMPLE_W-1:0]      in_tdata,
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [p2d_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                   out_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [p2d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [p2d_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import p2d_pkg::*;

  logic [CNT_W-1:0]  frame_rows_r, frame_cols_r;
  logic [POOL_W-1:0] pool_size_r;
  logic              pool_mode_r;
  logic              dirty_r;
  logic              cfg_fire;

  logic [CNT_W-1:0]  rows_eff, cols_eff;
  logic [POOL_W-1:0] p_eff;
  logic [AREA_W-1:0] p_ext, area;

  logic [CNT_W-1:0]   h_r, w_r;
  logic [POS_W-1:0]   row_r, row_nxt, col_r, col_nxt;
  logic [POS_W-1:0]   br_r, br_nxt, bc_r, bc_nxt;
  logic [PHASE_W-1:0] wr_r, wr_nxt, wc_r, wc_nxt;
  logic [CNT_W-1:0]   row_inc, col_inc, row_tmp;
  logic [PHASE_W-1:0] p_last;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SUM_W-1:0]    sample_ext;
  logic signed [SUM_W-1:0]    rd_sum, sum_new, acc_sum_r;
  logic signed [SAMPLE_W-1:0] rd_max, max_new, acc_max_r;
  logic [SAMPLE_W-1:0]        avg_r;
  logic                       first, in_window, win_last, frame_last;

  logic [DIV_W-1:0]  div_dividend, div_quo, sum_mag;
  logic [AREA_W-1:0] div_divisor, div_rem;
  logic [DIV_W-1:0]  avg_full;
  logic              div_done;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_value_r;
  logic [POS_W-1:0]    out_row_r, out_col_r;
  logic                out_last_r;
  logic                out_free;

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r <= CNT_W'(1);
      frame_cols_r <= CNT_W'(1);
      pool_size_r  <= POOL_W'(2);
      pool_mode_r  <= 1'b1;
      dirty_r      <= 1'b1;
    end else begin
      if (cmd.sync_clear) begin
        dirty_r <= 1'b0;
      end
      if (cfg_fire) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FRAME_ROWS: begin
            frame_rows_r <= cfg_data;
            dirty_r      <= 1'b1;
          end
          CFG_FRAME_COLUMNS: begin
            frame_cols_r <= cfg_data;
            dirty_r      <= 1'b1;
          end
          CFG_POOL_SIZE: begin
            pool_size_r <= cfg_data[POOL_W-1:0];
            dirty_r     <= 1'b1;
          end
          CFG_POOL_MODE: pool_mode_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (frame_rows_r == '0) begin
      rows_eff = CNT_W'(1);
    end else if (frame_rows_r > CNT_W'(MAX_ROWS)) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = frame_rows_r;
    end
    if (frame_cols_r == '0) begin
      cols_eff = CNT_W'(1);
    end else if (frame_cols_r > CNT_W'(MAX_COLUMNS)) begin
      cols_eff = CNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = frame_cols_r;
    end
    if (pool_size_r == '0) begin
      p_eff = POOL_W'(1);
    end else if (pool_size_r > POOL_W'(MAX_POOL)) begin
      p_eff = POOL_W'(MAX_POOL);
    end else begin
      p_eff = pool_size_r;
    end
  end

  assign p_ext  = {{(AREA_W-POOL_W){1'b0}}, p_eff};
  assign area   = p_ext * p_ext;
  assign p_last = PHASE_W'(p_eff - 1'b1);

  // shared divider: frame bands, position phases, window average
  assign sum_mag = acc_sum_r[SUM_W-1] ? DIV_W'(-acc_sum_r) : DIV_W'(acc_sum_r);

  always_comb begin
    div_divisor = p_ext;
    case (cmd.div_sel)
      DIV_ROWS: div_dividend = {{(DIV_W-CNT_W){1'b0}}, rows_eff};
      DIV_COLS: div_dividend = {{(DIV_W-CNT_W){1'b0}}, cols_eff};
      DIV_RPOS: div_dividend = {{(DIV_W-POS_W){1'b0}}, row_r};
      DIV_CPOS: div_dividend = {{(DIV_W-POS_W){1'b0}}, col_r};
      DIV_AVG: begin
        div_dividend = sum_mag;
        div_divisor  = area;
      end
      default: div_dividend = '0;
    endcase
  end

  p2d_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .remainder(div_rem),
    .done     (div_done)
  );

  assign avg_full = acc_sum_r[SUM_W-1] ? (~div_quo + 1'b1) : div_quo;

  // position and window phase
  assign row_inc = {1'b0, row_r} + 1'b1;
  assign col_inc = {1'b0, col_r} + 1'b1;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    br_nxt  = br_r;
    bc_nxt  = bc_r;
    wr_nxt  = wr_r;
    wc_nxt  = wc_r;
    row_tmp = {1'b0, row_r};
    if (cmd.accept) begin
      if (in_tuser) begin
        row_nxt = '0;
        col_nxt = '0;
        br_nxt  = '0;
        bc_nxt  = '0;
        wr_nxt  = '0;
        wc_nxt  = '0;
      end else begin
        // wrap a position left outside a shrunken frame
        if ({1'b0, col_r} >= cols_eff) begin
          col_nxt = '0;
          row_tmp = row_inc;
        end
        if (row_tmp >= rows_eff) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_tmp[POS_W-1:0];
        end
      end
    end else if (cmd.div_store) begin
      case (cmd.div_sel)
        DIV_RPOS: begin
          br_nxt = div_quo[POS_W-1:0];
          wr_nxt = div_rem[PHASE_W-1:0];
        end
        DIV_CPOS: begin
          bc_nxt = div_quo[POS_W-1:0];
          wc_nxt = div_rem[PHASE_W-1:0];
        end
        default: ;
      endcase
    end else if (cmd.advance) begin
      if (col_inc >= cols_eff) begin
        col_nxt = '0;
        bc_nxt  = '0;
        wc_nxt  = '0;
        if (row_inc >= rows_eff) begin
          row_nxt = '0;
          br_nxt  = '0;
          wr_nxt  = '0;
        end else begin
          row_nxt = row_inc[POS_W-1:0];
          if (wr_r == p_last) begin
            wr_nxt = '0;
            br_nxt = br_r + 1'b1;
          end else begin
            wr_nxt = wr_r + 1'b1;
          end
        end
      end else begin
        col_nxt = col_inc[POS_W-1:0];
        if (wc_r == p_last) begin
          wc_nxt = '0;
          bc_nxt = bc_r + 1'b1;
        end else begin
          wc_nxt = wc_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      br_r  <= '0;
      bc_r  <= '0;
      wr_r  <= '0;
      wc_r  <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      br_r  <= br_nxt;
      bc_r  <= bc_nxt;
      wr_r  <= wr_nxt;
      wc_r  <= wc_nxt;
    end
    if (cmd.div_store) begin
      case (cmd.div_sel)
        DIV_ROWS: h_r   <= div_quo[CNT_W-1:0];
        DIV_COLS: w_r   <= div_quo[CNT_W-1:0];
        DIV_AVG:  avg_r <= avg_full[SAMPLE_W-1:0];
        default: ;
      endcase
    end
    if (cmd.accept) begin
      sample_r <= in_tdata;
    end
  end

  // window accumulation
  assign in_window  = ({1'b0, br_r} < h_r) && ({1'b0, bc_r} < w_r);
  assign win_last   = (wr_r == p_last) && (wc_r == p_last);
  assign first      = (wr_r == '0) && (wc_r == '0);
  assign frame_last = ({1'b0, br_r} == h_r - 1'b1) && ({1'b0, bc_r} == w_r - 1'b1);
  assign sample_ext = {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};

  always_comb begin
    if (first) begin
      sum_new = sample_ext;
      max_new = sample_r;
    end else begin
      sum_new = rd_sum + sample_ext;
      max_new = (sample_r > rd_max) ? sample_r : rd_max;
    end
  end

  p2d_ram #(.WIDTH(SUM_W), .DEPTH(MAX_COLUMNS)) u_sum_ram (
    .clk  (clk),
    .we   (cmd.ram_write && in_window),
    .waddr(bc_r[COL_AW-1:0]),
    .wdata(sum_new),
    .re   (cmd.ram_read),
    .raddr(bc_r[COL_AW-1:0]),
    .rdata(rd_sum)
  );

  p2d_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_COLUMNS)) u_max_ram (
    .clk  (clk),
    .we   (cmd.ram_write && in_window),
    .waddr(bc_r[COL_AW-1:0]),
    .wdata(max_new),
    .re   (cmd.ram_read),
    .raddr(bc_r[COL_AW-1:0]),
    .rdata(rd_max)
  );

  always_ff @(posedge clk) begin
    if (cmd.ram_write) begin
      acc_sum_r <= sum_new;
      acc_max_r <= max_new;
    end
  end

  // output register
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit_load) begin
      out_value_r <= pool_mode_r ? acc_max_r : avg_r;
      out_row_r   <= br_r;
      out_col_r   <= bc_r;
      out_last_r  <= frame_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_col_r, out_row_r, out_value_r};

  assign status.dirty    = dirty_r;
  assign status.div_done = div_done;
  assign status.emit     = in_window && win_last;
  assign status.mode_max = pool_mode_r;
  assign status.out_free = out_free;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken word");

  a_sync_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sync_clear && !cfg_fire) |=> !dirty_r)
    else $error("window phase still marked stale after resync");

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.advance && !cfg_fire) |=> ({1'b0, col_r} < cols_eff))
    else $error("column position left the frame");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    !dirty_r |-> (({1'b0, wc_r} < p_eff) && ({1'b0, wr_r} < p_eff)))
    else $error("window phase beyond pool size");

endmodule
`default_nettype wire

// File: rtl/p2d_ctrl.sv
`default_nettype none
module p2d_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire p2d_pkg::p2d_status_t status,
  output p2d_pkg::p2d_cmd_t         cmd
);
  import p2d_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SYNC      = 8'b0000_0010,
    S_SYNC_WAIT = 8'b0000_0100,
    S_READ      = 8'b0000_1000,
    S_CALC      = 8'b0001_0000,
    S_AVG       = 8'b0010_0000,
    S_DIV       = 8'b0100_0000,
    S_EMIT      = 8'b1000_0000
  } state_t;

  state_t   state_r, state_nxt;
  div_sel_t sel_r, sel_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.div_sel = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          sel_nxt    = DIV_ROWS;
          state_nxt  = status.dirty ? S_SYNC : S_READ;
        end
      end
      S_SYNC: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_SYNC_WAIT;
      end
      S_SYNC_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          case (sel_r)
            DIV_ROWS: sel_nxt = DIV_COLS;
            DIV_COLS: sel_nxt = DIV_RPOS;
            DIV_RPOS: sel_nxt = DIV_CPOS;
            default:  sel_nxt = DIV_ROWS;
          endcase
          if (sel_r == DIV_CPOS) begin
            cmd.sync_clear = 1'b1;
            state_nxt      = S_READ;
          end else begin
            state_nxt = S_SYNC;
          end
        end
      end
      S_READ: begin
        cmd.ram_read = 1'b1;
        state_nxt    = S_CALC;
      end
      S_CALC: begin
        cmd.ram_write = 1'b1;
        if (!status.emit) begin
          cmd.advance = 1'b1;
          state_nxt   = S_IDLE;
        end else if (status.mode_max) begin
          state_nxt = S_EMIT;
        end else begin
          sel_nxt   = DIV_AVG;
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.advance   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= DIV_ROWS;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> (state_r == S_SYNC_WAIT || state_r == S_DIV))
    else $error("divider finished with nobody waiting");

endmodule
`default_nettype wire

// File: rtl/pool_2d_max_average.sv
`default_nettype none
// Non-overlapping p-by-p max or average pooling over a row-major stream of
// signed Q8.8 samples. One word is taken at a time: each sample is read
// and accumulated; a sample that closes a window is then emitted in max
// mode, while in average mode a 22-step serial divider first forms
// sum / (p*p) truncated toward zero; a closing sample also holds while the
// output register still carries an untaken word. The per-column sum and
// maximum stores are RAMs read in the cycle before they are written back.
// After reset and after any write to frame_rows, frame_columns or pool_size
// the next sample runs four divisions to rebuild the window bands and phases.
// The window stores are not cleared; a band that is entered at its top-left
// sample is always well defined. frame_start on tuser restarts the matrix;
// tlast marks the final pooled value of a matrix.
module pool_2d_max_average (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [15:0] sample
  input  wire logic [p2d_pkg::SAMPLE_W-1:0]      in_tdata,
  // [0] frame_start
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [15:0] pooled_value, [25:16] out_row, [35:26] out_column, [39:36] zero
  output logic      [p2d_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                   out_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [p2d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [p2d_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import p2d_pkg::*;

  p2d_cmd_t    cmd;
  p2d_status_t status;

  p2d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  p2d_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire
